// ===== hw/rtl/apf_pkg.sv =====
// Shared types and constants for the scaled average pooling block.
`default_nettype none
package apf_pkg;

	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 17;
	localparam int STEP_W     = 4;
	localparam int RECIP_W    = 17;
	localparam int PIX_W      = 16;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_POOL_WIDTH    = 8'd3;
	localparam logic [CFG_IDX_W-1:0] REG_POOL_HEIGHT   = 8'd4;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_X        = 8'd5;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_Y        = 8'd6;
	localparam logic [CFG_IDX_W-1:0] REG_RECIP_AREA    = 8'd7;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_MUL1,
		S_MUL2,
		S_OUT
	} apf_state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/apf_ram.sv =====
// Generic simple dual-port RAM, one write port, one registered read port.
`default_nettype none
module apf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire [$clog2(DEPTH)-1:0]  waddr,
	input  wire [WIDTH-1:0]          wdata,
	input  wire                      re,
	input  wire [$clog2(DEPTH)-1:0]  raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/average_pool_scaled_forward.sv =====
// Top level of the scaled average pooling block.
//
// Usage:
//  - Pixels enter on the in_valid/in_ready channel, plane by plane, each plane
//    in raster order, together with the gain and bias of the current channel.
//  - Each request that completes a pool window yields one result on the
//    out_valid/out_ready channel; other requests give no result.
//  - Registers must be written over cfg_valid/cfg_ready only while the block
//    is idle; the block itself does not enforce this. A write to an index in
//    range restarts the frame at plane 0, row 0, column 0.
//  - A request takes a memory read, then update and write back; one that
//    completes a window then takes the two multiplies and rounding/saturation.
//    The next request is taken only once the memory round trip is done.
//  - The result sits in an output register; the next request is taken while
//    it waits. If the receiver stalls, a second completed window waits in the
//    final stage and input is held off until the output register frees up.
//  - Reset returns all registers to their defaults and the positions to zero.
//    Memories need no clearing: column sums are ignored on row 0 and the row
//    store is read only once a full window height has been written.
`default_nettype none
module average_pool_scaled_forward #(
	parameter int MAX_WIDTH    = 256,
	parameter int MAX_HEIGHT   = 256,
	parameter int MAX_POOL     = 8,
	parameter int MAX_CHANNELS = 64
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   cfg_valid,
	output logic                                  cfg_ready,
	input  wire [apf_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  wire [apf_pkg::CFG_DATA_W-1:0]         cfg_data,
	input  wire                                   in_valid,
	output logic                                  in_ready,
	input  wire signed [15:0]                     pixel,
	input  wire signed [15:0]                     channel_weight,
	input  wire signed [15:0]                     channel_bias,
	output logic                                  out_valid,
	input  wire                                   out_ready,
	output logic signed [15:0]                    pooled_value,
	output logic                                  end_of_channel,
	output logic                                  end_of_frame
);
	import apf_pkg::*;

	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int WW   = $clog2(MAX_WIDTH + 1);
	localparam int RW   = $clog2(MAX_HEIGHT);
	localparam int HW   = $clog2(MAX_HEIGHT + 1);
	localparam int PI   = $clog2(MAX_POOL);
	localparam int PW   = $clog2(MAX_POOL + 1);
	localparam int CHW  = $clog2(MAX_CHANNELS + 1);
	localparam int RSD  = MAX_WIDTH * MAX_POOL;
	localparam int AW   = $clog2(RSD);
	localparam int CSW  = PIX_W + PI;
	localparam int SUMW = PIX_W + 2 * PI;
	localparam int P1W  = SUMW + RECIP_W + 1;
	localparam int P2W  = P1W + PIX_W;
	localparam int QW   = P2W - 30;
	localparam int VW   = QW + 1;

	// configuration registers (raw)
	logic [8:0]          img_w_q, img_h_q;
	logic [6:0]          chan_q;
	logic [3:0]          pool_w_q, pool_h_q, step_x_q, step_y_q;
	logic [RECIP_W-1:0]  recip_q;

	// clamped views
	logic [WW-1:0]      w_c;
	logic [HW-1:0]      h_c;
	logic [CHW-1:0]     ch_c;
	logic [PW-1:0]      pw_c, ph_c;
	logic [STEP_W-1:0]  sx_c, sy_c;
	logic [RECIP_W:0]   recip_c;

	always_comb begin
		if (img_w_q == 9'd0) w_c = WW'(1);
		else if (32'(img_w_q) > MAX_WIDTH) w_c = WW'(MAX_WIDTH);
		else w_c = WW'(img_w_q);
		if (img_h_q == 9'd0) h_c = HW'(1);
		else if (32'(img_h_q) > MAX_HEIGHT) h_c = HW'(MAX_HEIGHT);
		else h_c = HW'(img_h_q);
		if (chan_q == 7'd0) ch_c = CHW'(1);
		else if (32'(chan_q) > MAX_CHANNELS) ch_c = CHW'(MAX_CHANNELS);
		else ch_c = CHW'(chan_q);
		if (pool_w_q == 4'd0) pw_c = PW'(1);
		else if (32'(pool_w_q) > MAX_POOL) pw_c = PW'(MAX_POOL);
		else pw_c = PW'(pool_w_q);
		if (pool_h_q == 4'd0) ph_c = PW'(1);
		else if (32'(pool_h_q) > MAX_POOL) ph_c = PW'(MAX_POOL);
		else ph_c = PW'(pool_h_q);
		if (step_x_q == 4'd0) sx_c = 4'd1;
		else if (step_x_q > 4'd8) sx_c = 4'd8;
		else sx_c = step_x_q;
		if (step_y_q == 4'd0) sy_c = 4'd1;
		else if (step_y_q > 4'd8) sy_c = 4'd8;
		else sy_c = step_y_q;
		if (recip_q > 17'd65536) recip_c = 18'd65536;
		else recip_c = {1'b0, recip_q};
	end

	// position state
	logic [CW-1:0]      col_q;
	logic [RW-1:0]      row_q;
	logic [CHW-1:0]     plane_q;
	logic [PI-1:0]      rmod_q, cmod_q;
	logic [2:0]         xcnt_q, ycnt_q;
	logic signed [SUMW-1:0] run_q;
	logic signed [CSW-1:0]  wcols_q [MAX_POOL];

	// request capture
	logic signed [15:0] pix_q, wt_q, bias_q;

	// window result pipeline
	logic signed [SUMW-1:0] sum_s1;
	logic signed [P1W-1:0]  prod_s2;
	logic signed [P2W-1:0]  prod_s3;
	logic                   eoc_s1, eof_s1;

	apf_state_t state_q, state_d;

	logic accept, cfg_wr, hit, load_out;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid;
	assign accept    = in_valid & in_ready;

	// memories
	logic [AW-1:0]          rs_addr;
	logic [15:0]            rs_rdata;
	logic [CSW-1:0]         cs_rdata;
	logic                   mem_wr;
	logic signed [CSW-1:0]  colsum;

	assign rs_addr = AW'(rmod_q) * AW'(MAX_WIDTH) + AW'(col_q);

	apf_ram #(.WIDTH(16), .DEPTH(RSD)) u_row_store (
		.clk   (clk),
		.we    (mem_wr),
		.waddr (rs_addr),
		.wdata (pix_q),
		.re    (accept),
		.raddr (rs_addr),
		.rdata (rs_rdata)
	);

	apf_ram #(.WIDTH(CSW), .DEPTH(MAX_WIDTH)) u_col_sums (
		.clk   (clk),
		.we    (mem_wr),
		.waddr (col_q),
		.wdata (colsum),
		.re    (accept),
		.raddr (col_q),
		.rdata (cs_rdata)
	);

	// update datapath (valid in S_RD)
	logic                   row_full, col_full, x_hit, y_hit;
	logic signed [CSW-1:0]  old_row, prev_cs;
	logic signed [CSW-1:0]  old_col;
	logic signed [SUMW-1:0] run_d;
	logic                   last_col, last_row, last_plane;

	always_comb begin
		row_full = (HW'(row_q) >= HW'(ph_c));
		col_full = (WW'(col_q) >= WW'(pw_c));
		old_row  = row_full ? CSW'(signed'(rs_rdata)) : '0;
		prev_cs  = (row_q == '0) ? '0 : signed'(cs_rdata);
		colsum   = prev_cs + CSW'(pix_q) - old_row;
		old_col  = col_full ? wcols_q[cmod_q] : '0;
		run_d    = ((col_q == '0) ? '0 : run_q) + SUMW'(colsum) - SUMW'(old_col);
		x_hit    = ((WW+1)'(col_q) + 1'b1 >= (WW+1)'(pw_c)) && (xcnt_q == 3'd0);
		y_hit    = ((HW+1)'(row_q) + 1'b1 >= (HW+1)'(ph_c)) && (ycnt_q == 3'd0);
		hit      = x_hit && y_hit;
		last_col = ((WW+1)'(col_q) + 1'b1 == (WW+1)'(w_c));
		last_row = ((HW+1)'(row_q) + 1'b1 == (HW+1)'(h_c));
		last_plane = ((CHW+1)'(plane_q) + 1'b1 == (CHW+1)'(ch_c));
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (accept) state_d = S_RD;
			S_RD:   state_d = hit ? S_MUL1 : S_IDLE;
			S_MUL1: state_d = S_MUL2;
			S_MUL2: state_d = S_OUT;
			S_OUT:  if (!out_valid || out_ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_ready = 1'b0;
		mem_wr   = 1'b0;
		load_out = 1'b0;
		case (state_q)
			S_IDLE: in_ready = 1'b1;
			S_RD:   mem_wr = 1'b1;
			S_OUT:  load_out = !out_valid || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w_q  <= 9'd28;
			img_h_q  <= 9'd28;
			chan_q   <= 7'd1;
			pool_w_q <= 4'd2;
			pool_h_q <= 4'd2;
			step_x_q <= 4'd2;
			step_y_q <= 4'd2;
			recip_q  <= 17'd16384;
		end else if (cfg_wr) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:   img_w_q  <= cfg_data[8:0];
				REG_IMAGE_HEIGHT:  img_h_q  <= cfg_data[8:0];
				REG_CHANNEL_COUNT: chan_q   <= cfg_data[6:0];
				REG_POOL_WIDTH:    pool_w_q <= cfg_data[3:0];
				REG_POOL_HEIGHT:   pool_h_q <= cfg_data[3:0];
				REG_STEP_X:        step_x_q <= cfg_data[3:0];
				REG_STEP_Y:        step_y_q <= cfg_data[3:0];
				REG_RECIP_AREA:    recip_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// positions; a register write (index in range) restarts the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			plane_q <= '0;
			rmod_q  <= '0;
			cmod_q  <= '0;
			xcnt_q  <= '0;
			ycnt_q  <= '0;
			run_q   <= '0;
		end else if (cfg_wr && cfg_index <= REG_RECIP_AREA) begin
			col_q   <= '0;
			row_q   <= '0;
			plane_q <= '0;
			rmod_q  <= '0;
			cmod_q  <= '0;
			xcnt_q  <= '0;
			ycnt_q  <= '0;
			run_q   <= '0;
		end else if (state_q == S_RD) begin
			run_q <= run_d;
			if (last_col) begin
				col_q  <= '0;
				cmod_q <= '0;
				xcnt_q <= '0;
				if (last_row) begin
					row_q  <= '0;
					rmod_q <= '0;
					ycnt_q <= '0;
					plane_q <= last_plane ? '0 : plane_q + 1'b1;
				end else begin
					row_q  <= row_q + 1'b1;
					rmod_q <= ((PW)'(rmod_q) + 1'b1 == ph_c) ? '0 : rmod_q + 1'b1;
					if ((HW+1)'(row_q) + 1'b1 >= (HW+1)'(ph_c))
						ycnt_q <= ({1'b0, ycnt_q} + 1'b1 == sy_c) ? '0 : ycnt_q + 1'b1;
				end
			end else begin
				col_q  <= col_q + 1'b1;
				cmod_q <= ((PW)'(cmod_q) + 1'b1 == pw_c) ? '0 : cmod_q + 1'b1;
				if ((WW+1)'(col_q) + 1'b1 >= (WW+1)'(pw_c))
					xcnt_q <= ({1'b0, xcnt_q} + 1'b1 == sx_c) ? '0 : xcnt_q + 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			pix_q  <= pixel;
			wt_q   <= channel_weight;
			bias_q <= channel_bias;
		end
		if (state_q == S_RD) begin
			wcols_q[cmod_q] <= colsum;
			sum_s1 <= run_d;
			eoc_s1 <= x_hit && y_hit
				&& ((WW+1)'(col_q) + (WW+1)'(sx_c) >= (WW+1)'(w_c))
				&& ((HW+1)'(row_q) + (HW+1)'(sy_c) >= (HW+1)'(h_c));
			eof_s1 <= last_plane;
		end
		if (state_q == S_MUL1) begin
			prod_s2 <= P1W'(sum_s1) * P1W'(signed'(recip_c));
		end
		if (state_q == S_MUL2) begin
			prod_s3 <= P2W'(prod_s2) * P2W'(wt_q);
		end
	end

	// round half up to Q8.8, add bias, saturate
	logic signed [P2W-1:0] rounded;
	logic signed [QW-1:0]  q_val;
	logic signed [VW-1:0]  v_val;
	logic signed [15:0]    sat_val;

	always_comb begin
		rounded = prod_s3 + P2W'(64'sd1 <<< 29);
		q_val   = QW'(rounded >>> 30);
		v_val   = VW'(q_val) + VW'(bias_q);
		if (v_val > VW'(32767)) sat_val = 16'sh7FFF;
		else if (v_val < -VW'(32768)) sat_val = 16'sh8000;
		else sat_val = 16'(v_val);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load_out) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			pooled_value   <= sat_val;
			end_of_channel <= eoc_s1;
			end_of_frame   <= eoc_s1 && eof_s1;
		end
	end

endmodule
`default_nettype wire

// ===== verif/tb_average_pool_scaled_forward.sv =====
// Self-checking testbench for the scaled average pooling block.
`default_nettype none
module tb_average_pool_scaled_forward;
	import apf_pkg::*;

	// Index past the register file: the block must ignore it.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'd9;
	localparam int NUM_REGS = 8;
	localparam int LINE_W   = 256;
	localparam int POOL_MAX = 8;

	typedef struct packed {
		logic signed [15:0] pix;
		logic signed [15:0] gain;
		logic signed [15:0] bias;
	} pixel_req_t;

	typedef struct packed {
		logic signed [15:0] value;
		logic               eoc;
		logic               eof;
	} pooled_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic signed [15:0]    pixel;
	logic signed [15:0]    channel_weight;
	logic signed [15:0]    channel_bias;
	logic                  out_valid;
	logic                  out_ready;
	logic signed [15:0]    pooled_value;
	logic                  end_of_channel;
	logic                  end_of_frame;

	average_pool_scaled_forward dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.pixel(pixel), .channel_weight(channel_weight), .channel_bias(channel_bias),
		.out_valid(out_valid), .out_ready(out_ready),
		.pooled_value(pooled_value),
		.end_of_channel(end_of_channel), .end_of_frame(end_of_frame)
	);

	// ---------------------------------------------------------------
	// Shared testbench state
	// ---------------------------------------------------------------
	pixel_req_t pixel_q[$];    // requests waiting for the driver
	pooled_t    pooled_q[$];   // predicted results, oldest first
	int         fail_cnt;
	int         res_cnt;
	bit         quiet;         // no idling near the end of the run

	// Predictor state, mirrors the block's architectural state
	int                 reg_val[NUM_REGS];
	logic signed [15:0] line_mem[LINE_W*POOL_MAX];
	int                 col_sum[LINE_W];
	int                 win_col[POOL_MAX];
	int                 win_sum;
	int                 col_pos, row_pos, plane;

	function automatic int clip(int v, int lo, int hi);
		return (v < lo) ? lo : (v > hi) ? hi : v;
	endfunction

	function void frame_restart();
		for (int i = 0; i < LINE_W; i++) col_sum[i] = 0;
		for (int i = 0; i < POOL_MAX; i++) win_col[i] = 0;
		win_sum = 0;
		col_pos = 0;
		row_pos = 0;
		plane   = 0;
	endfunction

	function void reg_defaults();
		reg_val[REG_IMAGE_WIDTH]   = 28;
		reg_val[REG_IMAGE_HEIGHT]  = 28;
		reg_val[REG_CHANNEL_COUNT] = 1;
		reg_val[REG_POOL_WIDTH]    = 2;
		reg_val[REG_POOL_HEIGHT]   = 2;
		reg_val[REG_STEP_X]        = 2;
		reg_val[REG_STEP_Y]        = 2;
		reg_val[REG_RECIP_AREA]    = 16384;
		frame_restart();
	endfunction

	// Register widths truncate the written data; out-of-range indexes do nothing.
	function void reg_update(int idx, int data);
		int mask;
		if (idx >= NUM_REGS)
			return;
		case (idx)
			REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT: mask = 'h1FF;
			REG_CHANNEL_COUNT:                 mask = 'h7F;
			REG_RECIP_AREA:                    mask = 'h1FFFF;
			default:                           mask = 'hF;
		endcase
		reg_val[idx] = data & mask;
		frame_restart();
	endfunction

	// One accepted pixel: update line/column/window sums, return 1 on a window hit.
	function bit pool_pixel(pixel_req_t rq, output pooled_t res);
		int w, h, ch, pw, ph, sx, sy, recip, idx, slot, prev, last_x, last_y;
		longint prod, q;
		bit hit;
		w     = clip(reg_val[REG_IMAGE_WIDTH], 1, 256);
		h     = clip(reg_val[REG_IMAGE_HEIGHT], 1, 256);
		ch    = clip(reg_val[REG_CHANNEL_COUNT], 1, 64);
		pw    = clip(reg_val[REG_POOL_WIDTH], 1, 8);
		ph    = clip(reg_val[REG_POOL_HEIGHT], 1, 8);
		sx    = clip(reg_val[REG_STEP_X], 1, 8);
		sy    = clip(reg_val[REG_STEP_Y], 1, 8);
		recip = clip(reg_val[REG_RECIP_AREA], 0, 65536);
		res   = '0;
		if (col_pos >= w || row_pos >= h || plane >= ch)
			frame_restart();
		if (col_pos == 0 && row_pos == 0)
			for (int i = 0; i < LINE_W; i++) col_sum[i] = 0;
		// vertical sum over the last ph rows
		idx  = (row_pos % ph) * LINE_W + col_pos;
		prev = (row_pos >= ph) ? int'(line_mem[idx]) : 0;
		line_mem[idx] = rq.pix;
		col_sum[col_pos] = col_sum[col_pos] + int'(rq.pix) - prev;
		// horizontal sum over the last pw columns
		if (col_pos == 0)
			win_sum = 0;
		slot = col_pos % pw;
		prev = (col_pos >= pw) ? win_col[slot] : 0;
		win_col[slot] = col_sum[col_pos];
		win_sum = win_sum + col_sum[col_pos] - prev;
		hit = (col_pos + 1 >= pw) && (row_pos + 1 >= ph) &&
			((col_pos + 1 - pw) % sx == 0) && ((row_pos + 1 - ph) % sy == 0);
		if (hit) begin
			prod = longint'(win_sum) * longint'(recip) * longint'(rq.gain);
			q = ((prod + (64'sd1 <<< 29)) >>> 30) + longint'(rq.bias);
			q = (q > 32767) ? 32767 : (q < -32768) ? -32768 : q;
			last_x = ((w - pw) / sx) * sx + pw - 1;
			last_y = ((h - ph) / sy) * sy + ph - 1;
			res.value = q[15:0];
			res.eoc   = (col_pos == last_x) && (row_pos == last_y);
			res.eof   = res.eoc && (plane + 1 == ch);
		end
		col_pos++;
		if (col_pos == w) begin
			col_pos = 0;
			row_pos++;
			if (row_pos == h) begin
				row_pos = 0;
				plane++;
				if (plane == ch)
					plane = 0;
			end
		end
		return hit;
	endfunction

	// ---------------------------------------------------------------
	// Clock and reset
	// ---------------------------------------------------------------
	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
	end

	// ---------------------------------------------------------------
	// Driver: pops requests, predicts on each accepted one.
	// Idles in random bursts unless quiet.
	// ---------------------------------------------------------------
	int in_gap;
	always @(posedge clk or negedge arst_n) begin
		pooled_t res;
		if (!arst_n) begin
			in_valid       <= 0;
			pixel          <= '0;
			channel_weight <= '0;
			channel_bias   <= '0;
			in_gap         = 0;
		end else begin
			if (in_valid && in_ready) begin
				if (pool_pixel({pixel, channel_weight, channel_bias}, res))
					pooled_q.push_back(res);
			end
			if (!in_valid || in_ready) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 0;
				end else if (pixel_q.size() > 0) begin
					pixel_req_t rq;
					rq = pixel_q.pop_front();
					pixel          <= rq.pix;
					channel_weight <= rq.gain;
					channel_bias   <= rq.bias;
					in_valid       <= 1;
					if (!quiet && $urandom_range(0, 15) == 0)
						in_gap = $urandom_range(1, 19);
				end else begin
					in_valid <= 0;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Receiver back-pressure, in its own process. One long hold-off
	// once traffic is flowing so the block fills and stalls its input.
	// ---------------------------------------------------------------
	int  stall_left;
	bit  long_stall_done;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready       <= 1;
			stall_left      = 0;
			long_stall_done = 0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= (stall_left == 0);
		end else if (!long_stall_done && res_cnt >= 60) begin
			long_stall_done = 1;
			stall_left      = 400;
			out_ready       <= 0;
		end else if (!quiet && $urandom_range(0, 11) == 0) begin
			stall_left = $urandom_range(1, 19);
			out_ready  <= 0;
		end else begin
			out_ready <= 1;
		end
	end

	// ---------------------------------------------------------------
	// Monitor: compare each result with the oldest prediction
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		pooled_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			res_cnt++;
			if (pooled_q.size() == 0) begin
				$error("unexpected result: pooled_value=%0d", pooled_value);
				fail_cnt++;
			end else begin
				exp_r = pooled_q.pop_front();
				if (pooled_value !== exp_r.value) begin
					$error("pooled_value: expected %0d, got %0d", exp_r.value, pooled_value);
					fail_cnt++;
				end
				if (end_of_channel !== exp_r.eoc) begin
					$error("end_of_channel: expected %0b, got %0b", exp_r.eoc, end_of_channel);
					fail_cnt++;
				end
				if (end_of_frame !== exp_r.eof) begin
					$error("end_of_frame: expected %0b, got %0b", exp_r.eof, end_of_frame);
					fail_cnt++;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------
	function automatic logic [15:0] rand_word();
		case ($urandom_range(0, 3))
			0:       return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
			1:       return 16'($signed($urandom_range(0, 1023)) - 512);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic push_pixels(int n);
		pixel_req_t rq;
		for (int i = 0; i < n; i++) begin
			rq.pix  = rand_word();
			rq.gain = rand_word();
			rq.bias = rand_word();
			pixel_q.push_back(rq);
		end
	endtask

	// Block must be fully drained before a register write.
	task automatic wait_drained();
		while (pixel_q.size() > 0 || in_valid || pooled_q.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Called right after a rising edge; returns with valid low after the write.
	task automatic reg_write(logic [CFG_IDX_W-1:0] idx, int data);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_W'(data);
		do @(posedge clk); while (!cfg_ready);
		reg_update(idx, data);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	task automatic setup(int w, int h, int ch, int pw, int ph, int sx, int sy, int recip);
		wait_drained();
		reg_write(REG_IMAGE_WIDTH, w);
		reg_write(REG_IMAGE_HEIGHT, h);
		reg_write(REG_CHANNEL_COUNT, ch);
		reg_write(REG_POOL_WIDTH, pw);
		reg_write(REG_POOL_HEIGHT, ph);
		reg_write(REG_STEP_X, sx);
		reg_write(REG_STEP_Y, sy);
		reg_write(REG_RECIP_AREA, recip);
	endtask

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------
	initial begin
		pixel_req_t rq;
		int w, h, ch, pw, ph, sx, sy, recip, sent, plane_px;
		cfg_valid = 0;
		cfg_index = '0;
		cfg_data  = '0;
		fail_cnt  = 0;
		res_cnt   = 0;
		quiet     = 0;
		reg_defaults();
		@(posedge arst_n);
		@(posedge clk);

		// defaults: a few rows of the 28x28 plane with 2x2 pooling
		push_pixels(3 * 28);

		// 1x1 pool, full reciprocal: every pixel yields a result; field extremes
		setup(4, 4, 1, 1, 1, 1, 1, 65536);
		for (int i = 0; i < 16; i++) begin
			rq.pix  = (i % 4 == 0) ? 16'h7FFF : (i % 4 == 1) ? 16'h8000 :
				(i % 4 == 2) ? 16'h0000 : 16'hFFFF;
			rq.gain = (i / 4 == 0) ? 16'h7FFF : (i / 4 == 1) ? 16'h8000 :
				(i / 4 == 2) ? 16'h4000 : 16'hC000;
			rq.bias = (i % 3 == 0) ? 16'h7FFF : (i % 3 == 1) ? 16'h8000 : 16'h0000;
			pixel_q.push_back(rq);
		end

		// zero size, count and step registers read as 1; oversized values clamp to their maxima
		setup(0, 0, 0, 0, 0, 0, 0, 0);
		push_pixels(3);
		setup(5, 2, 127, 15, 15, 15, 15, 'h1FFFF);
		push_pixels(10);
		// window larger than the plane: no results at all
		setup(3, 3, 2, 5, 5, 1, 1, 1000);
		push_pixels(18);
		// widest plane, then tallest plane, max channel count on tiny planes
		setup('h1FF, 2, 1, 8, 2, 8, 1, 4096);
		push_pixels(512);
		setup(1, 256, 1, 1, 8, 1, 7, 8192);
		push_pixels(256);
		setup(1, 1, 64, 1, 1, 1, 1, 65535);
		push_pixels(64);
		// mid-frame write restarts the frame; unknown index is ignored
		setup(6, 6, 2, 3, 3, 3, 3, 7282);
		push_pixels(40);
		wait_drained();
		reg_write(REG_UNUSED, 'h1FFFF);
		push_pixels(72);

		// random phases: about 1075 directed requests above, these bring
		// the total near 1800
		sent = 0;
		while (sent < 725) begin
			w  = $urandom_range(1, 14);
			h  = $urandom_range(1, 14);
			ch = $urandom_range(1, 3);
			pw = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 8) : $urandom_range(1, clip(w, 1, 8));
			ph = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 8) : $urandom_range(1, clip(h, 1, 8));
			sx = $urandom_range(1, 8);
			sy = $urandom_range(1, 8);
			recip = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 'h1FFFF)) :
				65536 / (pw * ph);
			setup(w, h, ch, pw, ph, sx, sy, recip);
			plane_px = w * h * ch * $urandom_range(1, 2);
			if ($urandom_range(0, 5) == 0)
				plane_px += $urandom_range(1, w * h);
			if (plane_px > 725 - sent)
				plane_px = 725 - sent;
			if (sent + plane_px >= 525)
				quiet = 1;
			push_pixels(plane_px);
			sent += plane_px;
		end
		quiet = 1;

		wait_drained();
		repeat (30) @(posedge clk);
		if (fail_cnt == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// run limit, far beyond the slowest correct run
	initial begin
		#(8 * 2000000);
		$display("TEST FAILED");
		$finish;
	end

endmodule
`default_nettype wire
